// ===== hdl/video_register_port_vram_macros.svh =====
// assertion macros shared by the register port rtl
// no dependencies; files that check their own logic include this header
`ifndef VIDEO_REGISTER_PORT_VRAM_MACROS_SVH
`define VIDEO_REGISTER_PORT_VRAM_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define VRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define VRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define VRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/vrp_pkg.sv =====
// types, codes and constants of the video register port
// no dependencies; used by vrp_front, vrp_back and the top level
package vrp_pkg;

   // store depths
   localparam int NT_DEPTH_DEF  = 2048;
   localparam int CHR_DEPTH_DEF = 8192;
   localparam int PAL_DEPTH_DEF = 32;
   localparam int OAM_DEPTH_DEF = 256;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // bus address bits that reach the stores
   localparam int ADDR_W = 14;

   // request function codes
   localparam logic [1:0] FUNC_READ      = 2'd0;
   localparam logic [1:0] FUNC_WRITE     = 2'd1;
   localparam logic [1:0] FUNC_VBL_BEGIN = 2'd2;
   localparam logic [1:0] FUNC_VBL_END   = 2'd3;

   // register numbers
   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   // control register bits
   localparam int CTRL_NMI_BIT   = 7;
   localparam int CTRL_INC32_BIT = 2;

   // palette page in the upper address bits
   localparam logic [5:0] PAL_PAGE = 6'h3F;

   // data port steps
   localparam logic [ADDR_W-1:0] STEP_COL = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] STEP_ROW = ADDR_W'(32);

   // classified command
   typedef enum logic [3:0] {
      OP_NOP,
      OP_RD_STATUS,
      OP_RD_OAM,
      OP_RD_DATA,
      OP_WR_CTRL,
      OP_WR_OAM_ADDR,
      OP_WR_OAM_DATA,
      OP_WR_SCROLL,
      OP_WR_ADDR,
      OP_WR_DATA,
      OP_VBL_BEGIN,
      OP_VBL_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   // head of the command queue as seen by the back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // back-to-front control
   typedef struct packed {
      logic pop;
      logic busy;
   } back_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

endpackage

// ===== hdl/video_register_port_vram.sv =====
// a register command's result word is loaded into the result register when the back takes it from the queue;
// a data-port or sprite attribute read first waits in BK_READ for the registered store read
// rate: one word a cycle for register commands while rsp_ready is high; a read holds off the next command
// until its store data is back; reset: state and stores clear; req_ready stays low during the sweep
// over the character store depth that zeroes the stores, one entry a cycle; csr writes are taken throughout
// top level; depends on vrp_pkg, vrp_front and vrp_back
module video_register_port_vram
   import vrp_pkg::*;
#(
   parameter int NAMETABLE_DEPTH   = NT_DEPTH_DEF,
   parameter int CHR_DEPTH         = CHR_DEPTH_DEF,
   parameter int PALETTE_DEPTH     = PAL_DEPTH_DEF,
   parameter int SPRITE_ATTR_DEPTH = OAM_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [2:0] req_reg_sel,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_nmi_request,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_vertical_mirroring
);

   queue_head_type  queue_head;
   back_status_type back_status;

   // mirroring register is always writable
   assign csr_ready = 1'b1;

   // accept and classify
   vrp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_reg_sel    (req_reg_sel),
      .req_write_data (req_write_data),
      .back_status    (back_status),
      .queue_head     (queue_head)
   );

   // execute against state and stores
   vrp_back #(
      .NAMETABLE_DEPTH   (NAMETABLE_DEPTH),
      .CHR_DEPTH         (CHR_DEPTH),
      .PALETTE_DEPTH     (PALETTE_DEPTH),
      .SPRITE_ATTR_DEPTH (SPRITE_ATTR_DEPTH)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .queue_head             (queue_head),
      .back_status            (back_status),
      .csr_valid              (csr_valid),
      .csr_vertical_mirroring (csr_vertical_mirroring),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_read_data          (rsp_read_data),
      .rsp_nmi_request        (rsp_nmi_request)
   );

endmodule

// ===== hdl/vrp_front.sv =====
// front of the register port: accepts bus words, classifies them into commands
// and holds them in a short queue; depends on vrp_pkg and the assertion macros
`include "video_register_port_vram_macros.svh"

module vrp_front
   import vrp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_func,
   input  logic [2:0]      req_reg_sel,
   input  logic [7:0]      req_write_data,
   input  back_status_type back_status,
   output queue_head_type  queue_head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   op_type           op_dec;
   logic             push;

   // classify the bus word
   always_comb begin
      op_dec = OP_NOP;
      case (req_func)
         FUNC_READ: begin
            case (req_reg_sel)
               REG_STATUS:   op_dec = OP_RD_STATUS;
               REG_OAM_DATA: op_dec = OP_RD_OAM;
               REG_DATA:     op_dec = OP_RD_DATA;
               default:      op_dec = OP_NOP;
            endcase
         end
         FUNC_WRITE: begin
            case (req_reg_sel)
               REG_CTRL:     op_dec = OP_WR_CTRL;
               REG_OAM_ADDR: op_dec = OP_WR_OAM_ADDR;
               REG_OAM_DATA: op_dec = OP_WR_OAM_DATA;
               REG_SCROLL:   op_dec = OP_WR_SCROLL;
               REG_ADDR:     op_dec = OP_WR_ADDR;
               REG_DATA:     op_dec = OP_WR_DATA;
               // mask only feeds rendering; status writes are ignored
               default:      op_dec = OP_NOP;
            endcase
         end
         FUNC_VBL_BEGIN: op_dec = OP_VBL_BEGIN;
         FUNC_VBL_END:   op_dec = OP_VBL_END;
         default:        op_dec = OP_NOP;
      endcase
   end

   // handshake, held off while the queue is full or the stores are being cleared
   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH)) && !back_status.busy;
   assign push      = req_valid && req_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (back_status.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !back_status.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && back_status.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{op: op_dec, data: req_write_data};
      end
   end

   assign queue_head.valid = (count_ff != '0);
   assign queue_head.cmd   = queue_ff[rd_ptr_ff];

   `VRP_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `VRP_ASSERT_IMP(a_pop_nonempty, clock, reset, back_status.pop, count_ff != '0, "pop from empty queue")
   `VRP_ASSERT_NEXT(a_cnt_grow, clock, reset, push && !back_status.pop, count_ff == $past(count_ff) + CNT_W'(1), "queue count did not grow on push")

endmodule

// ===== hdl/vrp_back.sv =====
// back of the register port: register state, video stores, read sequencing
// and the result register; depends on vrp_pkg and the assertion macros
`include "video_register_port_vram_macros.svh"

module vrp_back
   import vrp_pkg::*;
#(
   parameter int NAMETABLE_DEPTH   = NT_DEPTH_DEF,
   parameter int CHR_DEPTH         = CHR_DEPTH_DEF,
   parameter int PALETTE_DEPTH     = PAL_DEPTH_DEF,
   parameter int SPRITE_ATTR_DEPTH = OAM_DEPTH_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  queue_head_type  queue_head,
   output back_status_type back_status,
   input  logic            csr_valid,
   input  logic            csr_vertical_mirroring,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_nmi_request
);

   localparam int NT_AW  = $clog2(NAMETABLE_DEPTH);
   localparam int CHR_AW = $clog2(CHR_DEPTH);
   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int OAM_AW = $clog2(SPRITE_ATTR_DEPTH);
   localparam int CLR_AW = CHR_AW;

   // stores
   logic [7:0] nt_mem  [NAMETABLE_DEPTH];
   logic [7:0] chr_mem [CHR_DEPTH];
   logic [7:0] pal_mem [PALETTE_DEPTH];
   logic [7:0] oam_mem [SPRITE_ATTR_DEPTH];

   // register state
   back_state_type      state_ff, state_in;
   logic                mirror_ff;
   logic                nmi_en_ff, nmi_en_in;
   logic                inc32_ff, inc32_in;
   logic                vblank_ff, vblank_in;
   logic                toggle_ff, toggle_in;
   logic [ADDR_W-1:0]   temp_ff, temp_in;
   logic [ADDR_W-1:0]   cur_ff, cur_in;
   logic [7:0]          rbuf_ff, rbuf_in;
   logic [OAM_AW-1:0]   oam_idx_ff, oam_idx_in;
   logic                pend_data_ff, pend_data_in;
   logic                pend_pal_ff, pend_pal_in;
   logic                pend_chr_ff, pend_chr_in;

   // clearing sweep
   logic                clr_busy_ff;
   logic [CLR_AW-1:0]   clr_cnt_ff;

   // result register
   logic                rsp_valid_ff;
   logic [7:0]          rsp_data_ff, rsp_data_in;
   logic                rsp_nmi_ff, rsp_nmi_in;
   logic                rsp_load;

   // store ports
   logic [NT_AW-1:0]    nt_addr;
   logic [CHR_AW-1:0]   chr_addr;
   logic [PAL_AW-1:0]   pal_addr;
   logic [OAM_AW-1:0]   spr_port_addr;
   logic                nt_we, chr_we, pal_we, oam_we;
   logic                nt_wr, chr_wr, pal_wr, oam_wr;
   logic [7:0]          wr_data;
   logic [7:0]          nt_q, chr_q, pal_q, oam_q;

   logic                out_free;
   logic                pop;
   logic                is_pal, is_chr;
   logic [NT_AW-1:0]    nt_idx;
   logic [PAL_AW-1:0]   pal_idx;
   logic [ADDR_W-1:0]   step;
   logic [7:0]          d;

   assign d        = queue_head.cmd.data;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == BK_IDLE) && queue_head.valid && out_free && !clr_busy_ff;

   // address decode of the current bus address
   assign is_pal  = (cur_ff[ADDR_W-1:ADDR_W-6] == PAL_PAGE);
   assign is_chr  = !cur_ff[ADDR_W-1];
   assign nt_idx  = NT_AW'({(mirror_ff ? cur_ff[10] : cur_ff[11]), cur_ff[9:0]});
   assign pal_idx = PAL_AW'({(cur_ff[4] && (cur_ff[1:0] == 2'b00)) ? 1'b0 : cur_ff[4],
                             cur_ff[3:0]});
   assign step    = inc32_ff ? STEP_ROW : STEP_COL;

   // store ports: the clearing sweep takes them over after reset
   assign chr_addr      = clr_busy_ff ? clr_cnt_ff[CHR_AW-1:0] : cur_ff[CHR_AW-1:0];
   assign nt_addr       = clr_busy_ff ? clr_cnt_ff[NT_AW-1:0]  : nt_idx;
   assign pal_addr      = clr_busy_ff ? clr_cnt_ff[PAL_AW-1:0] : pal_idx;
   assign spr_port_addr = clr_busy_ff ? clr_cnt_ff[OAM_AW-1:0] : oam_idx_ff;
   assign wr_data  = clr_busy_ff ? 8'h00 : d;
   assign chr_we   = clr_busy_ff || chr_wr;
   assign nt_we    = clr_busy_ff || nt_wr;
   assign pal_we   = clr_busy_ff || pal_wr;
   assign oam_we   = clr_busy_ff || oam_wr;

   // command execution and read sequencing
   always_comb begin
      state_in     = state_ff;
      nmi_en_in    = nmi_en_ff;
      inc32_in     = inc32_ff;
      vblank_in    = vblank_ff;
      toggle_in    = toggle_ff;
      temp_in      = temp_ff;
      cur_in       = cur_ff;
      rbuf_in      = rbuf_ff;
      oam_idx_in   = oam_idx_ff;
      pend_data_in = pend_data_ff;
      pend_pal_in  = pend_pal_ff;
      pend_chr_in  = pend_chr_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = 8'h00;
      rsp_nmi_in   = 1'b0;
      chr_wr       = 1'b0;
      nt_wr        = 1'b0;
      pal_wr       = 1'b0;
      oam_wr       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               rsp_load = 1'b1;
               case (queue_head.cmd.op)
                  OP_RD_STATUS: begin
                     rsp_data_in = {vblank_ff, 2'b00, rbuf_ff[4:0]};
                     vblank_in   = 1'b0;
                     toggle_in   = 1'b0;
                  end
                  OP_RD_OAM: begin
                     rsp_load     = 1'b0;
                     pend_data_in = 1'b0;
                     state_in     = BK_READ;
                  end
                  OP_RD_DATA: begin
                     rsp_load     = 1'b0;
                     pend_data_in = 1'b1;
                     pend_pal_in  = is_pal;
                     pend_chr_in  = is_chr;
                     cur_in       = cur_ff + step;
                     state_in     = BK_READ;
                  end
                  OP_WR_CTRL: begin
                     nmi_en_in      = d[CTRL_NMI_BIT];
                     inc32_in       = d[CTRL_INC32_BIT];
                     temp_in[11:10] = d[1:0];
                  end
                  OP_WR_OAM_ADDR: begin
                     oam_idx_in = OAM_AW'(d);
                  end
                  OP_WR_OAM_DATA: begin
                     oam_wr     = 1'b1;
                     oam_idx_in = oam_idx_ff + OAM_AW'(1);
                  end
                  OP_WR_SCROLL: begin
                     if (!toggle_ff) begin
                        temp_in[4:0] = d[7:3];
                        toggle_in    = 1'b1;
                     end else begin
                        temp_in[13:12] = d[1:0];
                        temp_in[9:5]   = d[7:3];
                        toggle_in      = 1'b0;
                     end
                  end
                  OP_WR_ADDR: begin
                     if (!toggle_ff) begin
                        temp_in[13:8] = d[5:0];
                        toggle_in     = 1'b1;
                     end else begin
                        temp_in[7:0] = d;
                        cur_in       = {temp_ff[13:8], d};
                        toggle_in    = 1'b0;
                     end
                  end
                  OP_WR_DATA: begin
                     chr_wr = is_chr;
                     nt_wr  = !is_chr && !is_pal;
                     pal_wr = is_pal;
                     cur_in = cur_ff + step;
                  end
                  OP_VBL_BEGIN: begin
                     vblank_in  = 1'b1;
                     rsp_nmi_in = nmi_en_ff;
                  end
                  OP_VBL_END: begin
                     vblank_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ: begin
            // store data is back, finish the read
            rsp_load = 1'b1;
            state_in = BK_IDLE;
            if (pend_data_ff) begin
               rsp_data_in = pend_pal_ff ? pal_q : rbuf_ff;
               rbuf_in     = pend_chr_ff ? chr_q : nt_q;
            end else begin
               rsp_data_in = oam_q;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         mirror_ff  <= 1'b0;
         nmi_en_ff  <= 1'b0;
         inc32_ff   <= 1'b0;
         vblank_ff  <= 1'b0;
         toggle_ff  <= 1'b0;
         temp_ff    <= '0;
         cur_ff     <= '0;
         rbuf_ff    <= 8'h00;
         oam_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         if (csr_valid) begin
            mirror_ff <= csr_vertical_mirroring;
         end
         nmi_en_ff  <= nmi_en_in;
         inc32_ff   <= inc32_in;
         vblank_ff  <= vblank_in;
         toggle_ff  <= toggle_in;
         temp_ff    <= temp_in;
         cur_ff     <= cur_in;
         rbuf_ff    <= rbuf_in;
         oam_idx_ff <= oam_idx_in;
      end
   end

   // pending read kind
   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      pend_pal_ff  <= pend_pal_in;
      pend_chr_ff  <= pend_chr_in;
   end

   // clearing sweep over the depth of the character store
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + CLR_AW'(1);
         if (clr_cnt_ff == CLR_AW'(CHR_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // stores, single port with registered read
   always_ff @(posedge clock) begin
      if (chr_we) begin
         chr_mem[chr_addr] <= wr_data;
      end
      chr_q <= chr_mem[chr_addr];
   end

   always_ff @(posedge clock) begin
      if (nt_we) begin
         nt_mem[nt_addr] <= wr_data;
      end
      nt_q <= nt_mem[nt_addr];
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_addr] <= wr_data;
      end
      pal_q <= pal_mem[pal_addr];
   end

   always_ff @(posedge clock) begin
      if (oam_we) begin
         oam_mem[spr_port_addr] <= wr_data;
      end
      oam_q <= oam_mem[spr_port_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_nmi_ff  <= rsp_nmi_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_nmi_request  = rsp_nmi_ff;
   assign back_status.pop  = pop;
   assign back_status.busy = clr_busy_ff;

   `VRP_ASSERT_IMP(a_no_pop_clear, clock, reset, pop, !clr_busy_ff, "command taken during clearing sweep")
   `VRP_ASSERT_NEXT(a_read_done, clock, reset, state_ff == BK_READ, rsp_valid_ff && state_ff == BK_IDLE, "read did not finish in one cycle")
   `VRP_ASSERT_IMP(a_load_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten before taken")

endmodule
